// ===== sv/psr_pkg.sv =====
// Shared types, constants and helpers for the point sorter.
// Used by psr_cell and point_sorter_by_coordinate_top; depends on nothing else.
`default_nettype none

package psr_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COORD_W  = 16;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  // Register map.
  localparam logic [PADDR_W-1:0] ADDR_SORT_KEY = 3'd0;

  // Cell operations.
  localparam logic [1:0] MODE_HOLD  = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_SORT  = 2'd2;
  localparam logic [1:0] MODE_SHIFT = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       key_sel;    // 1 compares x, 0 compares y
    logic       pair_left;  // this cell is the lower of its pair in this round
    logic       pair_live;  // both cells of the pair hold stored points
  } cell_ctrl_t;

  function automatic logic signed [COORD_W-1:0] key_of(point_t p, logic by_x);
    return by_x ? p.x : p.y;
  endfunction

endpackage

`default_nettype wire

// ===== sv/psr_cell.sv =====
// One cell of the sorting chain: holds a single point and loads, swaps with a
// neighbour or shifts down. Depends on psr_pkg.
`default_nettype none

module psr_cell (
  input  wire logic               clk,
  input  wire psr_pkg::cell_ctrl_t ctrl,
  input  wire psr_pkg::point_t    load_pt,
  input  wire psr_pkg::point_t    left_pt,
  input  wire psr_pkg::point_t    right_pt,
  output psr_pkg::point_t         pt
);

  logic            take_right;
  logic            take_left;
  psr_pkg::point_t pt_next;

  // Only strictly greater keys move, which keeps equal keys in arrival order.
  always_comb begin
    take_right = ctrl.pair_live && ctrl.pair_left &&
                 (psr_pkg::key_of(pt, ctrl.key_sel) > psr_pkg::key_of(right_pt, ctrl.key_sel));
    take_left  = ctrl.pair_live && !ctrl.pair_left &&
                 (psr_pkg::key_of(left_pt, ctrl.key_sel) > psr_pkg::key_of(pt, ctrl.key_sel));
  end

  always_comb begin
    pt_next = pt;
    unique case (ctrl.mode)
      psr_pkg::MODE_LOAD:  pt_next = load_pt;
      psr_pkg::MODE_SORT: begin
        if (take_right) begin
          pt_next = right_pt;
        end else if (take_left) begin
          pt_next = left_pt;
        end
      end
      psr_pkg::MODE_SHIFT: pt_next = right_pt;
      default:             pt_next = pt;
    endcase
  end

  always_ff @(posedge clk) begin
    pt <= pt_next;
  end

endmodule

`default_nettype wire

// ===== sv/point_sorter_by_coordinate_top.sv =====
// Loading takes one point per cycle. After the beat marked last, n odd-even
// exchange rounds run in the cell chain (n = points stored, one round a cycle),
// then the n sorted points leave one per cycle from cell 0 while the receiver
// is ready.
// Reset is synchronous: the store empties, the overflow flag clears and the
// sort key selects x. Cell contents are not reset.
`default_nettype none

module point_sorter_by_coordinate_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // point input
  input  wire logic                              point_valid,
  output logic                                   point_ready,
  input  wire logic signed [psr_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [psr_pkg::COORD_W-1:0] point_y,
  input  wire logic                              last_point,
  // sorted output
  output logic                                   sorted_valid,
  input  wire logic                              sorted_ready,
  output logic signed [psr_pkg::COORD_W-1:0]     sorted_x,
  output logic signed [psr_pkg::COORD_W-1:0]     sorted_y,
  output logic                                   last_sorted,
  output logic                                   overflowed,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [psr_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [psr_pkg::DATA_W-1:0]        pwdata,
  output logic [psr_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]               state;
  logic [psr_pkg::CNT_W-1:0] occupancy;
  logic [psr_pkg::CNT_W-1:0] round;
  logic                     overflow_seen;
  logic                     sort_key_select;
  logic                     key_latched;

  logic                     in_beat;
  logic                     out_beat;
  logic                     cfg_write;
  logic                     store_full;
  psr_pkg::point_t          in_pt;
  psr_pkg::point_t          pts [psr_pkg::CAPACITY];

  always_comb begin
    point_ready  = (state == ST_LOAD);
    sorted_valid = (state == ST_EMIT);
    in_beat      = point_valid && point_ready;
    out_beat     = sorted_valid && sorted_ready;
    store_full   = (occupancy == psr_pkg::CNT_W'(psr_pkg::CAPACITY));
    in_pt.x      = point_x;
    in_pt.y      = point_y;
    cfg_write    = psel && penable && pwrite && pready && (paddr == psr_pkg::ADDR_SORT_KEY);
  end

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == psr_pkg::ADDR_SORT_KEY) begin
      prdata[0] = sort_key_select;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key_select <= 1'b1;
    end else if (cfg_write) begin
      sort_key_select <= pwdata[0];
    end
  end

  // Sequencer: load, exchange rounds, drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      occupancy     <= '0;
      round         <= '0;
      overflow_seen <= 1'b0;
      key_latched   <= 1'b1;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_beat) begin
            if (store_full) begin
              overflow_seen <= 1'b1;
            end else begin
              occupancy <= occupancy + psr_pkg::CNT_W'(1);
            end
            if (last_point) begin
              // The key in force when the last point arrives governs the set.
              key_latched <= sort_key_select;
              round       <= '0;
              state       <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          round <= round + psr_pkg::CNT_W'(1);
          if (round == occupancy - psr_pkg::CNT_W'(1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_beat) begin
            occupancy <= occupancy - psr_pkg::CNT_W'(1);
            if (occupancy == psr_pkg::CNT_W'(1)) begin
              overflow_seen <= 1'b0;
              state         <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // The chain of cells.
  for (genvar i = 0; i < psr_pkg::CAPACITY; i++) begin : g_cell
    localparam logic POS_ODD = 1'(i % 2);
    psr_pkg::point_t     left_pt;
    psr_pkg::point_t     right_pt;
    psr_pkg::cell_ctrl_t cell_ctrl;
    logic                live_as_left;
    logic                live_as_right;

    if (i == 0) begin : g_first
      assign left_pt       = '0;
      assign live_as_right = 1'b0;
    end else begin : g_inner
      assign left_pt       = pts[i-1];
      assign live_as_right = (psr_pkg::CNT_W'(i) < occupancy);
    end

    if (i == psr_pkg::CAPACITY - 1) begin : g_end
      assign right_pt = '0;
    end else begin : g_mid
      assign right_pt = pts[i+1];
    end

    assign live_as_left = (psr_pkg::CNT_W'(i + 1) < occupancy);

    always_comb begin
      cell_ctrl.key_sel   = key_latched;
      cell_ctrl.pair_left = (round[0] == POS_ODD);
      cell_ctrl.pair_live = cell_ctrl.pair_left ? live_as_left : live_as_right;
      if (state == ST_LOAD && in_beat && occupancy == psr_pkg::CNT_W'(i)) begin
        cell_ctrl.mode = psr_pkg::MODE_LOAD;
      end else if (state == ST_SORT) begin
        cell_ctrl.mode = psr_pkg::MODE_SORT;
      end else if (out_beat) begin
        cell_ctrl.mode = psr_pkg::MODE_SHIFT;
      end else begin
        cell_ctrl.mode = psr_pkg::MODE_HOLD;
      end
    end

    psr_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .load_pt  (in_pt),
      .left_pt  (left_pt),
      .right_pt (right_pt),
      .pt       (pts[i])
    );
  end

  always_comb begin
    sorted_x    = pts[0].x;
    sorted_y    = pts[0].y;
    last_sorted = (occupancy == psr_pkg::CNT_W'(1));
    overflowed  = overflow_seen;
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= psr_pkg::CNT_W'(psr_pkg::CAPACITY))
    else $error("store count beyond capacity");

  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(point_ready && sorted_valid))
    else $error("loading and draining at once");

  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    (point_valid && point_ready && last_point) |=> (state == ST_SORT && occupancy != '0))
    else $error("last point did not start a non-empty sort");

  a_drain_ends_set: assert property (@(posedge clk) disable iff (rst)
    (sorted_valid && sorted_ready && last_sorted) |=> (state == ST_LOAD && occupancy == '0
      && !overflow_seen))
    else $error("set not cleared after its final beat");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    sorted_valid |-> occupancy != '0)
    else $error("emitting from an empty store");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_point_sorter_by_coordinate_top.sv =====
// Self-checking testbench for point_sorter_by_coordinate_top: streams sets of
// points, predicts the stable sorted output of every set and checks each beat.
// Depends on psr_pkg and the sorter RTL only.
`default_nettype none

module tb_point_sorter_by_coordinate_top;

  localparam int SETTLE_CYCLES = 2 * psr_pkg::CAPACITY + 8;
  localparam int IDLE_LIMIT    = 2000;

  // Value styles for random coordinates.
  localparam int unsigned STYLE_WIDE    = 0;
  localparam int unsigned STYLE_TIES    = 1;
  localparam int unsigned STYLE_MIXED   = 2;
  localparam int unsigned STYLE_EXTREME = 3;

  // Receiver stall modes.
  localparam int unsigned RX_ALWAYS = 0;
  localparam int unsigned RX_MOSTLY = 1;
  localparam int unsigned RX_RARELY = 2;
  localparam int unsigned RX_SQUARE = 3;

  typedef struct packed {
    psr_pkg::point_t pt;
    logic            last;
  } point_beat_t;

  typedef struct packed {
    psr_pkg::point_t pt;
    logic            last;
    logic            ovf;
  } sorted_beat_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               point_valid = 1'b0;
  logic                               point_ready;
  logic signed [psr_pkg::COORD_W-1:0] point_x = '0;
  logic signed [psr_pkg::COORD_W-1:0] point_y = '0;
  logic                               last_point = 1'b0;
  logic                               sorted_valid;
  logic                               sorted_ready = 1'b0;
  logic signed [psr_pkg::COORD_W-1:0] sorted_x;
  logic signed [psr_pkg::COORD_W-1:0] sorted_y;
  logic                               last_sorted;
  logic                               overflowed;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [psr_pkg::PADDR_W-1:0]        paddr = '0;
  logic [psr_pkg::DATA_W-1:0]         pwdata = '0;
  logic [psr_pkg::DATA_W-1:0]         prdata;
  logic                               pready;

  point_sorter_by_coordinate_top uut (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_point   (last_point),
    .sorted_valid (sorted_valid),
    .sorted_ready (sorted_ready),
    .sorted_x     (sorted_x),
    .sorted_y     (sorted_y),
    .last_sorted  (last_sorted),
    .overflowed   (overflowed),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  point_beat_t  point_queue[$];
  sorted_beat_t sorted_expect_q[$];

  // Predictor state: the points held for the open set and the sort key.
  psr_pkg::point_t held_pt [psr_pkg::CAPACITY];
  int unsigned     held_count = 0;
  logic            held_dropped = 1'b0;
  logic            key_by_x = 1'b1;

  int unsigned error_count = 0;
  int unsigned points_taken = 0;
  int unsigned sets_sorted = 0;
  int unsigned overflow_sets = 0;
  int unsigned results_checked = 0;
  int unsigned key_writes = 0;
  int unsigned idle_cycles = 0;

  task automatic report_mismatch(string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Stores one accepted point and, on the last beat of a set, queues the set
  // in stable ascending order of the selected coordinate.
  task automatic absorb_point(logic signed [psr_pkg::COORD_W-1:0] px,
                              logic signed [psr_pkg::COORD_W-1:0] py, logic is_last);
    psr_pkg::point_t                    order [psr_pkg::CAPACITY];
    sorted_beat_t                       res;
    logic signed [psr_pkg::COORD_W-1:0] cur_key;
    logic signed [psr_pkg::COORD_W-1:0] prev_key;
    int                                 k;
    if (held_count < psr_pkg::CAPACITY) begin
      held_pt[held_count].x = px;
      held_pt[held_count].y = py;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!is_last) return;
    for (int i = 0; i < held_count; i++) begin
      cur_key = key_by_x ? held_pt[i].x : held_pt[i].y;
      k = i;
      while (k > 0) begin
        prev_key = key_by_x ? order[k-1].x : order[k-1].y;
        if (prev_key <= cur_key) break;
        order[k] = order[k-1];
        k--;
      end
      order[k] = held_pt[i];
    end
    for (int i = 0; i < held_count; i++) begin
      res.pt   = order[i];
      res.last = (i == held_count - 1);
      res.ovf  = held_dropped;
      sorted_expect_q.push_back(res);
    end
    sets_sorted++;
    if (held_dropped) overflow_sets++;
    held_count   = 0;
    held_dropped = 1'b0;
  endtask

  // Sender: bursts of random length separated by random gaps.
  logic        next_valid;
  point_beat_t beat;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else begin
      next_valid = point_valid;
      if (point_valid && point_ready) begin
        absorb_point(point_x, point_y, last_point);
        points_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (point_queue.size() > 0) begin
          beat = point_queue.pop_front();
          point_x    <= beat.pt.x;
          point_y    <= beat.pt.y;
          last_point <= beat.last;
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      point_valid <= next_valid;
    end
  end

  // Receiver: the stall mode is drawn at random whenever its countdown runs out.
  int unsigned rx_mode = RX_ALWAYS;
  int unsigned rx_count = 0;
  logic        next_ready;

  always @(posedge clk) begin
    if (rst) begin
      sorted_ready <= 1'b0;
    end else begin
      if (rx_count == 0) begin
        rx_mode  = $urandom_range(RX_ALWAYS, RX_SQUARE);
        rx_count = 40;
      end else begin
        rx_count--;
      end
      case (rx_mode)
        RX_ALWAYS: next_ready = 1'b1;
        RX_MOSTLY: next_ready = ($urandom_range(0, 3) != 0);
        RX_RARELY: next_ready = ($urandom_range(0, 3) == 0);
        default:   next_ready = rx_count[3];
      endcase
      sorted_ready <= next_ready;
    end
  end

  // Checker of the sorted beats.
  sorted_beat_t want;

  always @(posedge clk) begin
    if (!rst && sorted_valid && sorted_ready) begin
      if (sorted_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat x=%0d y=%0d", sorted_x, sorted_y));
      end else begin
        want = sorted_expect_q.pop_front();
        if (sorted_x !== want.pt.x)
          report_mismatch($sformatf("sorted_x %0d, expected %0d", sorted_x, want.pt.x));
        if (sorted_y !== want.pt.y)
          report_mismatch($sformatf("sorted_y %0d, expected %0d", sorted_y, want.pt.y));
        if (last_sorted !== want.last)
          report_mismatch($sformatf("last_sorted %b, expected %b", last_sorted, want.last));
        if (overflowed !== want.ovf)
          report_mismatch($sformatf("overflowed %b, expected %b", overflowed, want.ovf));
      end
      results_checked++;
    end
  end

  // Watchdog on cycles in which no beat or register access completes.
  always @(posedge clk) begin
    if (!rst) begin
      if ((point_valid && point_ready) || (sorted_valid && sorted_ready) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout: no progress for %0d cycles", IDLE_LIMIT);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  task automatic push_point(int px, int py, logic is_last);
    point_beat_t b;
    b.pt.x = psr_pkg::COORD_W'(px);
    b.pt.y = psr_pkg::COORD_W'(py);
    b.last = is_last;
    point_queue.push_back(b);
  endtask

  function automatic int pick_coord(int unsigned style);
    int unsigned r;
    case (style)
      STYLE_WIDE: return int'($signed(psr_pkg::COORD_W'($urandom())));
      STYLE_TIES: return int'($urandom_range(0, 6)) - 3;
      STYLE_EXTREME: begin
        r = $urandom_range(0, 3);
        case (r)
          0:       return 32767;
          1:       return -32768;
          2:       return 0;
          default: return -1;
        endcase
      end
      default: begin
        r = $urandom_range(0, 9);
        if (r < 6) return pick_coord(STYLE_WIDE);
        if (r < 8) return pick_coord(STYLE_TIES);
        return pick_coord(STYLE_EXTREME);
      end
    endcase
  endfunction

  task automatic queue_random_set(int unsigned n, logic closed);
    int unsigned style;
    style = $urandom_range(STYLE_WIDE, STYLE_MIXED);
    for (int unsigned i = 0; i < n; i++)
      push_point(pick_coord(style), pick_coord(style), closed && (i == n - 1));
  endtask

  // Mostly short sets, some up to the full store, a fifth of them overfull.
  task automatic queue_random_phase(int unsigned budget, logic leave_open);
    int unsigned used;
    int unsigned n;
    int unsigned r;
    used = 0;
    while (used < budget) begin
      r = $urandom_range(0, 99);
      if (r < 55) n = $urandom_range(1, 6);
      else if (r < 80) n = $urandom_range(7, psr_pkg::CAPACITY);
      else n = $urandom_range(psr_pkg::CAPACITY + 1, psr_pkg::CAPACITY + 5);
      queue_random_set(n, 1'b1);
      used += n;
    end
    if (leave_open && $urandom_range(0, 1) == 1)
      queue_random_set($urandom_range(1, 4), 1'b0);
  endtask

  // Waits until every queued point has gone in and every result has come out.
  task automatic settle();
    do @(negedge clk);
    while (point_queue.size() != 0 || point_valid || sorted_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_sort_key(logic by_x);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= psr_pkg::ADDR_SORT_KEY;
    pwdata  <= psr_pkg::DATA_W'(by_x);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    key_by_x = by_x;
    key_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== by_x)
      report_mismatch($sformatf("sort key reads back %b, expected %b", prdata[0], by_x));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sorting by x after reset: extremes, a single point, then ties on x.
    push_point(32767, -32768, 1'b0);
    push_point(-32768, 32767, 1'b0);
    push_point(0, 0, 1'b0);
    push_point(-1, 1, 1'b0);
    push_point(1, -1, 1'b1);
    push_point(-32768, -32768, 1'b1);
    push_point(5, 3, 1'b0);
    push_point(-2, 7, 1'b0);
    push_point(5, -9, 1'b0);
    push_point(5, 0, 1'b0);
    push_point(-2, -2, 1'b1);
    settle();
    write_sort_key(1'b0);

    // Ties on y, then a set left open across a key change: the key in force
    // when the last beat arrives must decide the order.
    push_point(1, 4, 1'b0);
    push_point(-6, 4, 1'b0);
    push_point(9, -3, 1'b0);
    push_point(2, 4, 1'b1);
    push_point(100, -50, 1'b0);
    push_point(-100, 50, 1'b0);
    push_point(0, -32768, 1'b0);
    settle();
    write_sort_key(1'b1);
    push_point(50, 0, 1'b0);
    push_point(-7, 32767, 1'b1);

    for (int p = 0; p < 4; p++) begin
      queue_random_phase(66, p < 3);
      settle();
      if (p < 3) write_sort_key(p[0] ? 1'b1 : 1'b0);
    end

    $display("Sent %0d points in %0d sets (%0d overflowed), checked %0d sorted beats,",
             points_taken, sets_sorted, overflow_sets, results_checked);
    $display("with %0d sort key writes covering both keys and %0d mismatches.",
             key_writes, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/psr_pkg.sv
sv/psr_cell.sv
sv/point_sorter_by_coordinate_top.sv
tb/tb_point_sorter_by_coordinate_top.sv
